/* sv/lht_pkg.sv */
// Shared types, codes and constants of the line header tokenizer.
package lht_pkg;

    // Token and line limits
    localparam int VERB_CAPACITY = 32;
    localparam int ARG_CAPACITY  = 255;
    localparam int ARG_LIMIT     = 16;

    // Result queue depth default
    localparam int QUEUE_DEPTH = 4;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_MAX_LEN = 1'b0;
    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    // Byte codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Input kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Result kinds
    localparam logic EV_CHAR    = 1'b0;
    localparam logic EV_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_PLAIN   = 2'd1,
        PH_QUOTED  = 2'd2,
        PH_ENDED   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNMATCHED = 2'd1,
        ST_TOO_LONG  = 2'd2
    } t_status;

    typedef struct packed {
        logic        event_res;
        logic [4:0]  token_number;
        logic [7:0]  char_position;
        logic [7:0]  char_value;
        logic        verb_present;
        logic [4:0]  argument_count;
        t_status     status;
    } t_result;

    // One accepted beat's results: r0 always, r1 when two is set
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

endpackage

/* sv/line_header_tokenizer_unit.sv */
// Top level of the line header tokenizer: config register, front, queue, back.
//
//  Channel   Dir  Handshake                  Payload
//  s_axis    in   i_s_axis_tvalid/o_tready   tdata: byte_in; tuser: kind
//  m_axis    out  o_m_axis_tvalid/i_tready   tdata: token..status; tuser: event_res;
//                                            tlast: last
//  apb       in   psel/penable/pwrite        paddr, pwdata, prdata; pready tied high
//
// One input beat is accepted per cycle while the result queue has room; the
// front tokenizes it in that cycle and pushes zero, one or two results as one
// queue entry. The back sends one result beat per cycle while the receiver is
// ready; an item with two results takes two beats. Results pass the queue and
// the back's entry register before the output. Synchronous active-low reset
// clears the line state, the queue and max_line_length (to 65535); no clearing
// pass. An output stall fills the queue, then drops o_s_axis_tready.
module line_header_tokenizer_unit #(
    parameter int QUEUE_DEPTH = lht_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Stream input
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,  // [7:0] byte_in
    input  logic                        i_s_axis_tuser,  // [0] kind
    // Result output
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [4:0] token_number, [12:5] char_position, [20:13] char_value,
    // [21] verb_present, [26:22] argument_count, [28:27] status, [31:29] zero
    output logic [31:0]                 o_m_axis_tdata,
    output logic                        o_m_axis_tuser,  // [0] event_res
    output logic                        o_m_axis_tlast,
    // Configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lht_pkg::PADDR_W-1:0] paddr,
    input  logic [lht_pkg::PDATA_W-1:0] pwdata,
    output logic [lht_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [15:0]     r_max_len;
    logic            cfg_wr;
    logic            q_push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    lht_pkg::t_entry q_in;
    lht_pkg::t_entry q_out;

    // Register index sits in address bit 2; other indexes are ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == lht_pkg::REG_MAX_LEN);
    assign prdata = (paddr[2] == lht_pkg::REG_MAX_LEN) ?
                    {{(lht_pkg::PDATA_W-16){1'b0}}, r_max_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lht_pkg::MAX_LEN_RESET;
        end else if (cfg_wr) begin
            r_max_len <= pwdata[15:0];
        end
    end

    lht_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_kind    (i_s_axis_tuser),
        .i_byte    (i_s_axis_tdata),
        .i_max_len (r_max_len),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_entry   (q_in)
    );

    lht_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_out),
        .i_pop   (q_pop)
    );

    lht_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (q_out),
        .o_pop    (q_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

/* sv/lht_front.sv */
// Front part: accepts input beats, tokenizes them and builds result entries.
module lht_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [7:0]         i_byte,
    input  logic [15:0]        i_max_len,
    input  logic               i_full,
    output logic               o_push,
    output lht_pkg::t_entry    o_entry
);

    localparam logic [8:0] VERB_CAP9  = 9'(lht_pkg::VERB_CAPACITY);
    localparam logic [8:0] ARG_CAP9   = 9'(lht_pkg::ARG_CAPACITY);
    localparam logic [4:0] ARG_LIMIT5 = 5'(lht_pkg::ARG_LIMIT);

    typedef struct packed {
        lht_pkg::t_phase phase;
        logic [7:0]      char_count;
        logic            verb_seen;
        logic [4:0]      arg_count;
        logic            dropped;
    } t_tok;

    typedef struct packed {
        t_tok             st;
        logic             emit;
        lht_pkg::t_result res;
    } t_tok_out;

    localparam t_tok TOK_CLEAR = '{lht_pkg::PH_BETWEEN, 8'd0, 1'b0, 5'd0, 1'b0};

    // One byte through the token state machine
    function automatic t_tok_out tokenize(t_tok s, logic [7:0] b);
        t_tok_out   o;
        t_tok       t;
        logic       put;
        logic [8:0] cap;
        t   = s;
        put = 1'b0;
        unique case (s.phase)
            lht_pkg::PH_BETWEEN: begin
                if (b == lht_pkg::CH_NUL) begin
                    t.phase   = lht_pkg::PH_ENDED;
                    t.dropped = 1'b0;
                end else if (b != lht_pkg::CH_SPACE) begin
                    t.char_count = 8'd0;
                    if (!t.verb_seen) begin
                        t.verb_seen = 1'b1;
                        t.dropped   = 1'b0;
                    end else if (t.arg_count < ARG_LIMIT5) begin
                        t.arg_count = t.arg_count + 5'd1;
                        t.dropped   = 1'b0;
                    end else begin
                        t.dropped = 1'b1;
                    end
                    if (b == lht_pkg::CH_QUOTE) begin
                        t.phase = lht_pkg::PH_QUOTED;
                    end else begin
                        t.phase = lht_pkg::PH_PLAIN;
                        put     = 1'b1;
                    end
                end
            end
            lht_pkg::PH_PLAIN: begin
                if (b == lht_pkg::CH_NUL) begin
                    t.phase   = lht_pkg::PH_ENDED;
                    t.dropped = 1'b0;
                end else if (b == lht_pkg::CH_SPACE) begin
                    t.phase = lht_pkg::PH_BETWEEN;
                end else begin
                    put = 1'b1;
                end
            end
            lht_pkg::PH_QUOTED: begin
                if (b == lht_pkg::CH_NUL) begin
                    t.phase   = lht_pkg::PH_ENDED;
                    t.dropped = 1'b1;
                end else if (b == lht_pkg::CH_QUOTE) begin
                    t.phase = lht_pkg::PH_BETWEEN;
                end else begin
                    put = 1'b1;
                end
            end
            lht_pkg::PH_ENDED: begin
            end
            default: begin
            end
        endcase
        cap   = (t.arg_count == 5'd0) ? VERB_CAP9 : ARG_CAP9;
        o.emit = 1'b0;
        o.res  = '0;
        if (put && !t.dropped && (({1'b0, t.char_count} + 9'd1) < cap)) begin
            o.emit                 = 1'b1;
            o.res.event_res        = lht_pkg::EV_CHAR;
            o.res.token_number     = t.arg_count;
            o.res.char_position    = t.char_count;
            o.res.char_value       = b;
            t.char_count           = t.char_count + 8'd1;
        end
        o.st = t;
        return o;
    endfunction

    t_tok        r_tok, n_tok;
    logic [15:0] r_line_bytes, n_line_bytes;
    logic        r_pending_cr, n_pending_cr;
    logic        r_ovf, n_ovf;

    t_tok_out    cr_out;
    t_tok        base;
    t_tok_out    byte_out;
    logic [16:0] len_inc;
    logic        accept;
    logic        cr_emit;
    logic        sec_emit;
    lht_pkg::t_result sec_res;
    lht_pkg::t_result sum_res;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign cr_out   = tokenize(r_tok, lht_pkg::CH_CR);
    assign base     = r_pending_cr ? cr_out.st : r_tok;
    assign cr_emit  = r_pending_cr && cr_out.emit;
    assign byte_out = tokenize(base, i_byte);
    assign len_inc  = {1'b0, r_line_bytes} + 17'd1;

    always_comb begin
        n_tok        = r_tok;
        n_line_bytes = r_line_bytes;
        n_pending_cr = r_pending_cr;
        n_ovf        = r_ovf;
        sec_emit     = 1'b0;
        sec_res      = '0;
        sum_res      = '0;
        if (accept) begin
            if (i_kind == lht_pkg::KIND_FLUSH) begin
                n_tok        = TOK_CLEAR;
                n_line_bytes = 16'd0;
                n_pending_cr = 1'b0;
                n_ovf        = 1'b0;
            end else if (!r_ovf) begin
                if (i_byte == lht_pkg::CH_LF) begin
                    sec_emit          = 1'b1;
                    sec_res.event_res = lht_pkg::EV_SUMMARY;
                    if (r_tok.phase == lht_pkg::PH_QUOTED ||
                        (r_tok.phase == lht_pkg::PH_ENDED && r_tok.dropped)) begin
                        sec_res.status = lht_pkg::ST_UNMATCHED;
                    end else begin
                        sec_res.verb_present   = r_tok.verb_seen;
                        sec_res.argument_count = r_tok.arg_count;
                        sec_res.status         = lht_pkg::ST_OK;
                    end
                    n_tok        = TOK_CLEAR;
                    n_line_bytes = 16'd0;
                    n_pending_cr = 1'b0;
                end else if (len_inc >= {1'b0, i_max_len}) begin
                    // Too long: drop this byte, report, then ignore until flush
                    sec_emit          = 1'b1;
                    sec_res.event_res = lht_pkg::EV_SUMMARY;
                    sec_res.status    = lht_pkg::ST_TOO_LONG;
                    n_tok             = TOK_CLEAR;
                    n_line_bytes      = 16'd0;
                    n_pending_cr      = 1'b0;
                    n_ovf             = 1'b1;
                end else if (i_byte == lht_pkg::CH_CR) begin
                    n_tok        = base;
                    n_line_bytes = len_inc[15:0];
                    n_pending_cr = 1'b1;
                end else begin
                    n_tok        = byte_out.st;
                    n_line_bytes = len_inc[15:0];
                    n_pending_cr = 1'b0;
                    sec_emit     = byte_out.emit;
                    sec_res      = byte_out.res;
                end
            end
        end
    end

    // Pack the held CR result first, then this byte's result
    logic do_cr;
    assign do_cr = accept && (i_kind == lht_pkg::KIND_BYTE) && !r_ovf &&
                   (i_byte != lht_pkg::CH_LF) && cr_emit;

    always_comb begin
        o_entry = '0;
        o_push  = 1'b0;
        if (do_cr) begin
            o_push     = 1'b1;
            o_entry.r0 = cr_out.res;
            o_entry.r1 = sec_res;
            o_entry.two = sec_emit;
        end else if (sec_emit) begin
            o_push     = 1'b1;
            o_entry.r0 = sec_res;
            o_entry.r1 = sum_res;
            o_entry.two = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok        <= TOK_CLEAR;
            r_line_bytes <= 16'd0;
            r_pending_cr <= 1'b0;
            r_ovf        <= 1'b0;
        end else begin
            r_tok        <= n_tok;
            r_line_bytes <= n_line_bytes;
            r_pending_cr <= n_pending_cr;
            r_ovf        <= n_ovf;
        end
    end

`ifndef ASSERT_OFF
    a_ovf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_tok.phase == lht_pkg::PH_BETWEEN && r_line_bytes == 16'd0 &&
                   !r_pending_cr))
        else $error("line state not cleared while in too-long error");
`endif

endmodule

/* sv/lht_queue.sv */
// Result queue between the tokenizer front and the output back.
module lht_queue #(
    parameter int DEPTH = lht_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lht_pkg::t_entry  i_entry,
    output logic             o_full,
    output logic             o_valid,
    output lht_pkg::t_entry  o_entry,
    input  logic             i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lht_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full && !i_pop) |=> o_full)
        else $error("queue left full state without a pop");
`endif

endmodule

/* sv/lht_back.sv */
// Back part: holds one queue entry and sends its results as output beats.
module lht_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lht_pkg::t_entry  i_entry,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [31:0]      o_tdata,
    output logic             o_tuser,
    output logic             o_tlast
);

    lht_pkg::t_entry  r_ent;
    logic             r_have;
    logic             r_idx;
    lht_pkg::t_result cur;
    logic             beat;

    assign cur      = r_idx ? r_ent.r1 : r_ent.r0;
    assign o_tvalid = r_have;
    assign o_tlast  = (r_idx == r_ent.two);
    assign o_tuser  = cur.event_res;
    assign o_tdata  = {3'b000, cur.status, cur.argument_count, cur.verb_present,
                       cur.char_value, cur.char_position, cur.token_number};
    assign beat     = r_have && i_tready;
    assign o_pop    = i_valid && (!r_have || (beat && o_tlast));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= 1'b0;
        end else if (o_pop) begin
            r_have <= 1'b1;
            r_idx  <= 1'b0;
        end else if (beat) begin
            if (o_tlast) begin
                r_have <= 1'b0;
                r_idx  <= 1'b0;
            end else begin
                r_idx <= 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_tuser == lht_pkg::EV_SUMMARY) |-> o_tlast)
        else $error("line summary not marked as last beat");
`endif

endmodule

/* test/line_header_tokenizer_unit_tb.sv */
// Self-checking testbench of the line header tokenizer: stream stimulus, APB setup, scoreboard.
module line_header_tokenizer_unit_tb;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int MAX_GAP       = 14;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 16;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int REG_SPARE     = 1;
    localparam int ADDR_W        = lht_pkg::PADDR_W;
    localparam int DATA_W        = lht_pkg::PDATA_W;

    localparam logic [ADDR_W-1:0] ADDR_MAX_LEN = ADDR_W'(4 * lht_pkg::REG_MAX_LEN);
    localparam logic [ADDR_W-1:0] ADDR_SPARE   = ADDR_W'(4 * REG_SPARE);

    // One result beat as seen on the master side
    typedef struct packed {
        lht_pkg::t_result res;
        logic             last;
    } t_result_beat;

    // Line tokenizer mirror plus the queue of beats it still expects
    class line_tokenizer_scoreboard;
        int              max_len;
        lht_pkg::t_phase ph;
        int              char_cnt;
        bit              verb_seen;
        int              arg_cnt;
        int              line_bytes;
        bit              cr_held;
        bit              overflow;
        bit              tok_dropped;
        int              errors;
        t_result_beat    expected[$];

        function new();
            max_len  = lht_pkg::MAX_LEN_RESET;
            overflow = 0;
            errors   = 0;
            clear_line();
        endfunction

        function void clear_line();
            ph          = lht_pkg::PH_BETWEEN;
            char_cnt    = 0;
            verb_seen   = 0;
            arg_cnt     = 0;
            line_bytes  = 0;
            cr_held     = 0;
            tok_dropped = 0;
        endfunction

        function void push_result(logic ev, int tok, int pos, logic [7:0] val,
                                  logic vp, int ac, lht_pkg::t_status st);
            t_result_beat rb;
            rb.res.event_res      = ev;
            rb.res.token_number   = 5'(tok);
            rb.res.char_position  = 8'(pos);
            rb.res.char_value     = val;
            rb.res.verb_present   = vp;
            rb.res.argument_count = 5'(ac);
            rb.res.status         = st;
            rb.last               = 1'b0;
            expected.push_back(rb);
        endfunction

        function void begin_token();
            char_cnt = 0;
            if (!verb_seen) begin
                verb_seen   = 1;
                tok_dropped = 0;
            end else if (arg_cnt < lht_pkg::ARG_LIMIT) begin
                arg_cnt++;
                tok_dropped = 0;
            end else begin
                tok_dropped = 1;
            end
        endfunction

        function void emit_char(logic [7:0] b);
            int cap;
            if (tok_dropped) return;
            cap = (arg_cnt == 0) ? lht_pkg::VERB_CAPACITY : lht_pkg::ARG_CAPACITY;
            // keep one slot free, as a C-style terminator would
            if (char_cnt + 1 < cap) begin
                push_result(lht_pkg::EV_CHAR, arg_cnt, char_cnt, b, 1'b0, 0,
                            lht_pkg::ST_OK);
                char_cnt++;
            end
        endfunction

        function void tokenize(logic [7:0] b);
            case (ph)
                lht_pkg::PH_BETWEEN: begin
                    if (b == lht_pkg::CH_NUL) begin
                        ph          = lht_pkg::PH_ENDED;
                        tok_dropped = 0;
                    end else if (b != lht_pkg::CH_SPACE) begin
                        begin_token();
                        if (b == lht_pkg::CH_QUOTE) begin
                            ph = lht_pkg::PH_QUOTED;
                        end else begin
                            ph = lht_pkg::PH_PLAIN;
                            emit_char(b);
                        end
                    end
                end
                lht_pkg::PH_PLAIN: begin
                    if (b == lht_pkg::CH_NUL) begin
                        ph          = lht_pkg::PH_ENDED;
                        tok_dropped = 0;
                    end else if (b == lht_pkg::CH_SPACE) begin
                        ph = lht_pkg::PH_BETWEEN;
                    end else begin
                        emit_char(b);
                    end
                end
                lht_pkg::PH_QUOTED: begin
                    // NUL inside an open quote leaves the line unmatched
                    if (b == lht_pkg::CH_NUL) begin
                        ph          = lht_pkg::PH_ENDED;
                        tok_dropped = 1;
                    end else if (b == lht_pkg::CH_QUOTE) begin
                        ph = lht_pkg::PH_BETWEEN;
                    end else begin
                        emit_char(b);
                    end
                end
                default: ;
            endcase
        endfunction

        // A beat swallowed by a sticky too-long error expects nothing
        function void note_input(logic kind, logic [7:0] data);
            int           first;
            t_result_beat tail;
            first = expected.size();
            if (kind == lht_pkg::KIND_FLUSH) begin
                clear_line();
                overflow = 0;
                return;
            end
            if (overflow) return;
            if (data == lht_pkg::CH_LF) begin
                if (ph == lht_pkg::PH_QUOTED || (ph == lht_pkg::PH_ENDED && tok_dropped))
                    push_result(lht_pkg::EV_SUMMARY, 0, 0, 8'h00, 1'b0, 0,
                                lht_pkg::ST_UNMATCHED);
                else
                    push_result(lht_pkg::EV_SUMMARY, 0, 0, 8'h00, verb_seen, arg_cnt,
                                lht_pkg::ST_OK);
                clear_line();
            end else begin
                // a held CR not followed by LF is an ordinary byte
                if (cr_held) begin
                    cr_held = 0;
                    tokenize(lht_pkg::CH_CR);
                end
                line_bytes++;
                if (line_bytes >= max_len) begin
                    push_result(lht_pkg::EV_SUMMARY, 0, 0, 8'h00, 1'b0, 0,
                                lht_pkg::ST_TOO_LONG);
                    clear_line();
                    overflow = 1;
                end else if (data == lht_pkg::CH_CR) begin
                    cr_held = 1;
                end else begin
                    tokenize(data);
                end
            end
            if (expected.size() > first) begin
                tail      = expected.pop_back();
                tail.last = 1'b1;
                expected.push_back(tail);
            end
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(t_result_beat act);
            t_result_beat exp;
            if (expected.size() == 0) begin
                $error("result beat with nothing pending: event_res %0d, tdata fields %h",
                       act.res.event_res, act.res);
                errors++;
                return;
            end
            exp = expected.pop_front();
            compare_field("event_res", exp.res.event_res, act.res.event_res);
            compare_field("token_number", exp.res.token_number, act.res.token_number);
            compare_field("char_position", exp.res.char_position, act.res.char_position);
            compare_field("char_value", exp.res.char_value, act.res.char_value);
            compare_field("verb_present", exp.res.verb_present, act.res.verb_present);
            compare_field("argument_count", exp.res.argument_count,
                          act.res.argument_count);
            compare_field("status", exp.res.status, act.res.status);
            compare_field("last", exp.last, act.last);
        endfunction
    endclass

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_s_axis_tvalid  = 1'b0;
    logic                o_s_axis_tready;
    logic [7:0]          i_s_axis_tdata   = 8'h00;  // [7:0] byte_in
    logic                i_s_axis_tuser   = 1'b0;   // [0] kind
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready  = 1'b0;
    // [4:0] token_number, [12:5] char_position, [20:13] char_value,
    // [21] verb_present, [26:22] argument_count, [28:27] status
    logic [31:0]         o_m_axis_tdata;
    logic                o_m_axis_tuser;            // [0] event_res
    logic                o_m_axis_tlast;
    logic                psel             = 1'b0;
    logic                penable          = 1'b0;
    logic                pwrite           = 1'b0;
    logic [ADDR_W-1:0]   paddr            = '0;
    logic [DATA_W-1:0]   pwdata           = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    line_tokenizer_scoreboard sb = new();

    bit          quiet     = 0;   // no idling on either side while set
    bit          hold_req  = 0;   // ask the receiver for one long hold-off
    bit          want_long = 0;   // next generated line carries a maximal argument
    int          items_sent = 0;
    int unsigned cycle_count = 0;

    line_header_tokenizer_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: stall a random number of cycles per beat, check every accepted beat
    initial begin
        int           stall;
        t_result_beat act;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 0;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            act.res.event_res      = o_m_axis_tuser;
            act.res.token_number   = o_m_axis_tdata[4:0];
            act.res.char_position  = o_m_axis_tdata[12:5];
            act.res.char_value     = o_m_axis_tdata[20:13];
            act.res.verb_present   = o_m_axis_tdata[21];
            act.res.argument_count = o_m_axis_tdata[26:22];
            act.res.status         = lht_pkg::t_status'(o_m_axis_tdata[28:27]);
            act.last               = o_m_axis_tlast;
            sb.check_result(act);
        end
    end

    // Offer one beat after a random gap; hold tvalid high on return
    task automatic send_item(logic kind, logic [7:0] data);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= data;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(kind, data);
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] data);
        send_item(lht_pkg::KIND_BYTE, data);
    endtask

    task automatic send_flush();
        send_item(lht_pkg::KIND_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Drop tvalid, wait for every pending beat, then let the pipeline settle
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};   // upper bits are not part of the register
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_LEN) sb.max_len = value;
        @(posedge i_clk);
    endtask

    // Ordinary token byte: never space, quote, NUL, CR or LF
    function automatic logic [7:0] token_char();
        if ($urandom_range(0, 5) == 0) return 8'($urandom_range(8'h80, 8'hFF));
        return 8'($urandom_range(8'h23, 8'h7E));
    endfunction

    function automatic int pick_len(int t);
        if (want_long && t == 1) begin
            want_long = 0;
            return $urandom_range(lht_pkg::ARG_CAPACITY - 3, lht_pkg::ARG_CAPACITY + 3);
        end
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(lht_pkg::VERB_CAPACITY - 3, lht_pkg::VERB_CAPACITY + 3);
        return $urandom_range(0, 6);
    endfunction

    // Mostly well-formed lines with random content, some raw noise
    task automatic send_line();
        int n_tok;
        int len;
        int t;
        int i;
        bit prev_closed;
        prev_closed = 0;
        // flush often where short limits make the error sticky
        if ($urandom_range(0, (sb.max_len < 100) ? 1 : 7) == 0) send_flush();
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
        end else begin
            n_tok = ($urandom_range(0, 7) == 0) ?
                    $urandom_range(lht_pkg::ARG_LIMIT - 1, lht_pkg::ARG_LIMIT + 3) :
                    $urandom_range(1, 4);
            for (t = 0; t < n_tok; t++) begin
                len = $urandom_range((t == 0 || prev_closed) ? 0 : 1, 3);
                repeat (len) send_byte(lht_pkg::CH_SPACE);
                len = pick_len(t);
                prev_closed = 0;
                if ($urandom_range(0, 3) == 0) begin
                    send_byte(lht_pkg::CH_QUOTE);
                    for (i = 0; i < len; i++)
                        send_byte(($urandom_range(0, 4) == 0) ? lht_pkg::CH_SPACE
                                                              : token_char());
                    // now and then leave the quote open
                    if ($urandom_range(0, 9) != 0) begin
                        send_byte(lht_pkg::CH_QUOTE);
                        prev_closed = 1;
                    end
                end else begin
                    send_byte(token_char());
                    for (i = 1; i < len; i++)
                        send_byte(($urandom_range(0, 7) == 0) ? lht_pkg::CH_QUOTE
                                                              : token_char());
                end
                if ($urandom_range(0, 19) == 0) send_byte(lht_pkg::CH_NUL);
                if ($urandom_range(0, 19) == 0) send_byte(lht_pkg::CH_CR);
            end
        end
        if ($urandom_range(0, 1) == 1) send_byte(lht_pkg::CH_CR);
        send_byte(lht_pkg::CH_LF);
    endtask

    task automatic run_items(int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            quiet = ($urandom_range(0, 4) == 0);
            send_line();
            // pause the sender until the output has caught up
            if ($urandom_range(0, 9) == 0) drain_results();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unknown register index must leave the limit alone
        apb_write(ADDR_SPARE, 16'h0005);

        // Directed: verb and argument with CR before LF
        send_text("G a");
        send_byte(lht_pkg::CH_CR);
        send_byte(lht_pkg::CH_LF);
        // quoted token with a space, empty quoted token, adjacent tokens,
        // quote inside a plain token, NUL ending the content
        send_text("\"x y\"\"\"b\"c");
        send_byte(lht_pkg::CH_NUL);
        send_text("z");
        send_byte(lht_pkg::CH_LF);
        // held CR followed by an ordinary byte, then an unmatched quote
        send_text("a");
        send_byte(lht_pkg::CH_CR);
        send_text("b \"q");
        send_byte(lht_pkg::CH_LF);
        // top byte value, then flush wiping the partial line
        send_byte(8'hFF);
        send_flush();
        send_byte(lht_pkg::CH_LF);
        drain_results();

        // Default limit with one maximal argument and a long output stall
        want_long = 1;
        run_items(30);
        hold_req = 1;
        quiet    = 1;
        repeat (4) send_line();
        quiet    = 0;
        run_items(15);
        drain_results();

        // Limit zero: the first non-LF byte of a line trips the error
        apb_write(ADDR_MAX_LEN, 16'h0000);
        run_items(10);
        drain_results();

        // Limit one: as with zero, the first non-LF byte of a line trips the error
        apb_write(ADDR_MAX_LEN, 16'h0001);
        run_items(10);
        drain_results();

        // Short limit: many lines overflow
        apb_write(ADDR_MAX_LEN, 16'd20);
        run_items(30);
        drain_results();

        apb_write(ADDR_MAX_LEN, 16'($urandom_range(40, 200)));
        run_items(30);
        drain_results();

        // Back to the largest limit, written explicitly
        apb_write(ADDR_MAX_LEN, lht_pkg::MAX_LEN_RESET);
        run_items(20);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
